@@ hw/rtl/dso_pkg.sv @@
// Shared constants, cell control types and sequencer states for the disk seek scheduler.
// Used by every module of the block and by its checker; depends on nothing.
package dso_pkg;

    localparam int MAX_REQ   = 16;
    localparam int CNT_W     = $clog2(MAX_REQ + 1);
    localparam int CYL_W     = 16;
    localparam int NCYL_W    = 17;
    localparam int SUM_W     = 18;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = ((CYL_W + SUM_W + 7) / 8) * 8;
    localparam int REG_IDX_W = 1;

    localparam logic [SUM_W-1:0]     SUM_MAX    = '1;
    localparam logic [NCYL_W-1:0]    NCYL_RESET = NCYL_W'(65536);
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_NCYL   = 1'b1;

    localparam logic MODE_CSCAN = 1'b0;
    localparam logic MODE_CLOOK = 1'b1;
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT,
        OP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [CYL_W-1:0] din;
        logic [CYL_W-1:0] wrap_val;
    } cell_ctl_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_ROTATE = 8'b0000_0010,
        ST_HI     = 8'b0000_0100,
        ST_END    = 8'b0000_1000,
        ST_ZERO   = 8'b0001_0000,
        ST_WRAP   = 8'b0010_0000,
        ST_LO     = 8'b0100_0000,
        ST_HEAD   = 8'b1000_0000
    } seq_state_t;

endpackage

@@ hw/rtl/dso_cell.sv @@
// One cell of the sorted request chain: holds one cylinder and inserts, shifts or rotates.
// Depends on dso_pkg.
module dso_cell (
    input  logic                     clk,
    input  dso_pkg::cell_ctl_t       ctl,
    input  logic                     occupied,
    input  logic                     tail,
    input  logic [dso_pkg::CYL_W-1:0] left_val,
    input  logic                     left_lt,
    input  logic [dso_pkg::CYL_W-1:0] right_val,
    output logic [dso_pkg::CYL_W-1:0] val,
    output logic                     lt
);

    logic [dso_pkg::CYL_W-1:0] val_reg;
    logic [dso_pkg::CYL_W-1:0] val_next;

    // An empty cell counts as larger than any request.
    assign lt  = !occupied || (ctl.din < val_reg);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        unique case (ctl.op)
            dso_pkg::OP_HOLD:
            begin
                val_next = val_reg;
            end
            dso_pkg::OP_INSERT:
            begin
                if (lt)
                begin
                    val_next = left_lt ? left_val : ctl.din;
                end
            end
            dso_pkg::OP_SHIFT:
            begin
                val_next = right_val;
            end
            dso_pkg::OP_ROTATE:
            begin
                val_next = tail ? ctl.wrap_val : right_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

@@ hw/rtl/dso_seq.sv @@
// Sequencer of the scheduler: request count, run state machine, movement sum and result register.
// Depends on dso_pkg; drives the cell chain through a cell operation.
module dso_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mode,
    input  logic [dso_pkg::CYL_W-1:0]    end_cyl,
    input  logic                         in_valid,
    input  logic                         in_kind,
    input  logic [dso_pkg::CYL_W-1:0]    in_pos,
    output logic                         in_ready,
    input  logic [dso_pkg::CYL_W-1:0]    first_val,
    output dso_pkg::cell_op_t            cell_op,
    output logic [dso_pkg::CNT_W-1:0]    count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dso_pkg::CYL_W-1:0]    out_cyl,
    output logic                         out_wrap,
    output logic [dso_pkg::SUM_W-1:0]    out_total,
    output logic                         out_last
);

    dso_pkg::seq_state_t state_reg, state_next;
    logic [dso_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [dso_pkg::CNT_W-1:0] rot_reg, rot_next;
    logic [dso_pkg::CNT_W-1:0] left_reg, left_next;
    logic [dso_pkg::CYL_W-1:0] head_reg, head_next;
    logic [dso_pkg::CYL_W-1:0] cur_reg, cur_next;
    logic [dso_pkg::CYL_W-1:0] min_reg, min_next;
    logic [dso_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic                      valid_reg, valid_next;
    logic [dso_pkg::CYL_W-1:0] ocyl_reg, ocyl_next;
    logic                      owrap_reg, owrap_next;
    logic [dso_pkg::SUM_W-1:0] ototal_reg, ototal_next;
    logic                      olast_reg, olast_next;

    logic                      can_load;
    logic                      emit;
    logic [dso_pkg::CYL_W-1:0] emit_cyl;
    logic                      emit_wrap;
    logic                      emit_last;
    logic [dso_pkg::CYL_W-1:0] seek_len;
    logic [dso_pkg::SUM_W:0]   sum_wide;
    logic [dso_pkg::SUM_W-1:0] sum_sat;

    assign can_load  = !valid_reg || out_ready;
    assign in_ready  = (state_reg == dso_pkg::ST_IDLE);
    assign count     = cnt_reg;
    assign out_valid = valid_reg;
    assign out_cyl   = ocyl_reg;
    assign out_wrap  = owrap_reg;
    assign out_total = ototal_reg;
    assign out_last  = olast_reg;

    assign seek_len = (emit_cyl >= cur_reg) ? (emit_cyl - cur_reg) : (cur_reg - emit_cyl);
    assign sum_wide = {1'b0, sum_reg} + (dso_pkg::SUM_W + 1)'(seek_len);
    assign sum_sat  = sum_wide[dso_pkg::SUM_W] ? dso_pkg::SUM_MAX : sum_wide[dso_pkg::SUM_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rot_next   = rot_reg;
        left_next  = left_reg;
        head_next  = head_reg;
        cur_next   = cur_reg;
        min_next   = min_reg;
        sum_next   = sum_reg;
        cell_op    = dso_pkg::OP_HOLD;
        emit       = 1'b0;
        emit_cyl   = first_val;
        emit_wrap  = 1'b0;
        emit_last  = 1'b0;

        unique case (state_reg)
            dso_pkg::ST_IDLE:
            begin
                if (in_valid && in_kind == dso_pkg::KIND_LOAD)
                begin
                    if (cnt_reg < dso_pkg::CNT_W'(dso_pkg::MAX_REQ))
                    begin
                        cell_op  = dso_pkg::OP_INSERT;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (in_valid)
                begin
                    head_next = in_pos;
                    cur_next  = in_pos;
                    min_next  = first_val;
                    sum_next  = '0;
                    rot_next  = '0;
                    if (mode == dso_pkg::MODE_CLOOK && cnt_reg == '0)
                    begin
                        state_next = dso_pkg::ST_HEAD;
                    end
                    else
                    begin
                        state_next = dso_pkg::ST_ROTATE;
                    end
                end
            end
            dso_pkg::ST_ROTATE:
            begin
                // Requests below the head move to the back of the chain.
                if (rot_reg < cnt_reg && first_val < head_reg)
                begin
                    cell_op  = dso_pkg::OP_ROTATE;
                    rot_next = rot_reg + 1'b1;
                end
                else
                begin
                    left_next  = cnt_reg - rot_reg;
                    state_next = dso_pkg::ST_HI;
                end
            end
            dso_pkg::ST_HI:
            begin
                if (left_reg == '0)
                begin
                    state_next = (mode == dso_pkg::MODE_CLOOK) ? dso_pkg::ST_WRAP
                                                               : dso_pkg::ST_END;
                end
                else if (can_load)
                begin
                    emit      = 1'b1;
                    cell_op   = dso_pkg::OP_SHIFT;
                    left_next = left_reg - 1'b1;
                end
            end
            dso_pkg::ST_END:
            begin
                emit_cyl = end_cyl;
                if (can_load)
                begin
                    emit       = 1'b1;
                    state_next = dso_pkg::ST_ZERO;
                end
            end
            dso_pkg::ST_ZERO,
            dso_pkg::ST_WRAP:
            begin
                emit_cyl  = (state_reg == dso_pkg::ST_ZERO) ? '0 : min_reg;
                emit_wrap = 1'b1;
                emit_last = (rot_reg == '0);
                if (can_load)
                begin
                    emit      = 1'b1;
                    left_next = rot_reg;
                    if (rot_reg == '0)
                    begin
                        cnt_next   = '0;
                        state_next = dso_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = dso_pkg::ST_LO;
                    end
                end
            end
            dso_pkg::ST_LO:
            begin
                emit_last = (left_reg == dso_pkg::CNT_W'(1));
                if (can_load)
                begin
                    emit      = 1'b1;
                    cell_op   = dso_pkg::OP_SHIFT;
                    left_next = left_reg - 1'b1;
                    if (left_reg == dso_pkg::CNT_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = dso_pkg::ST_IDLE;
                    end
                end
            end
            dso_pkg::ST_HEAD:
            begin
                emit_cyl  = head_reg;
                emit_last = 1'b1;
                if (can_load)
                begin
                    emit       = 1'b1;
                    cnt_next   = '0;
                    state_next = dso_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dso_pkg::ST_IDLE;
            end
        endcase

        if (emit)
        begin
            cur_next = emit_cyl;
            sum_next = sum_sat;
        end
    end

    always_comb
    begin
        valid_next  = valid_reg && !out_ready;
        ocyl_next   = ocyl_reg;
        owrap_next  = owrap_reg;
        ototal_next = ototal_reg;
        olast_next  = olast_reg;
        if (emit)
        begin
            valid_next  = 1'b1;
            ocyl_next   = emit_cyl;
            owrap_next  = emit_wrap;
            ototal_next = sum_sat;
            olast_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dso_pkg::ST_IDLE;
            cnt_reg   <= '0;
            rot_reg   <= '0;
            left_reg  <= '0;
            head_reg  <= '0;
            cur_reg   <= '0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rot_reg   <= rot_next;
            left_reg  <= left_next;
            head_reg  <= head_next;
            cur_reg   <= cur_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg    <= min_next;
        ocyl_reg   <= ocyl_next;
        owrap_reg  <= owrap_next;
        ototal_reg <= ototal_next;
        olast_reg  <= olast_next;
    end

endmodule

@@ hw/rtl/disk_seek_order_cscan_clook.sv @@
// Top level of the C-SCAN / C-LOOK disk seek scheduler: configuration registers,
// the chain of sorting cells and the sequencer. Depends on dso_pkg, dso_cell, dso_seq.
// A load beat is taken every cycle while the sequencer is idle and is sorted into the chain at once.
// A run beat holds the input off while the requests below the head are rotated and the visit beats
// of the run are emitted, in both modes and also for an empty C-LOOK run, plus any output stalls.
// Reset (asynchronous, active low) empties the store and restores C-SCAN over 65536 cylinders.
module disk_seek_order_cscan_clook (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dso_pkg::IN_DATA_W-1:0]     s_tdata,   // [15:0] position
    input  logic                              s_tuser,   // [0] kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dso_pkg::OUT_DATA_W-1:0]    m_tdata,   // [15:0] visit_cylinder, [33:16] total_movement
    output logic                              m_tuser,   // [0] is_wrap
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [dso_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  logic [dso_pkg::NCYL_W-1:0]        cfg_wdata
);

    logic                       mode_reg;
    logic [dso_pkg::NCYL_W-1:0] ncyl_reg;
    logic [dso_pkg::CYL_W-1:0]  end_cyl;

    dso_pkg::cell_ctl_t         ctl;
    dso_pkg::cell_op_t          cell_op;
    logic [dso_pkg::CNT_W-1:0]  count;
    logic [dso_pkg::CYL_W-1:0]  vals [dso_pkg::MAX_REQ];
    logic                       lts  [dso_pkg::MAX_REQ];

    logic [dso_pkg::CYL_W-1:0]  out_cyl;
    logic [dso_pkg::SUM_W-1:0]  out_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dso_pkg::MODE_CSCAN;
            ncyl_reg <= dso_pkg::NCYL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == dso_pkg::REG_MODE)
            begin
                mode_reg <= cfg_wdata[0];
            end
            else
            begin
                ncyl_reg <= cfg_wdata;
            end
        end
    end

    // The sweep ends at the last cylinder, clamped to the cylinder field.
    assign end_cyl = (ncyl_reg == '0) ? '0 :
                     (ncyl_reg[dso_pkg::NCYL_W-1] ? '1 :
                      (ncyl_reg[dso_pkg::CYL_W-1:0] - 1'b1));

    assign ctl.op       = cell_op;
    assign ctl.din      = s_tdata[dso_pkg::CYL_W-1:0];
    assign ctl.wrap_val = vals[0];

    for (genvar i = 0; i < dso_pkg::MAX_REQ; i++)
    begin : g_cell
        logic [dso_pkg::CYL_W-1:0] left_val;
        logic                      left_lt;
        logic [dso_pkg::CYL_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = ctl.din;
            assign left_lt  = 1'b0;
        end
        else
        begin : g_mid
            assign left_val = vals[i-1];
            assign left_lt  = lts[i-1];
        end

        if (i == dso_pkg::MAX_REQ - 1)
        begin : g_last
            assign right_val = ctl.din;
        end
        else
        begin : g_inner
            assign right_val = vals[i+1];
        end

        dso_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .occupied  (count > dso_pkg::CNT_W'(i)),
            .tail      (count == dso_pkg::CNT_W'(i + 1)),
            .left_val  (left_val),
            .left_lt   (left_lt),
            .right_val (right_val),
            .val       (vals[i]),
            .lt        (lts[i])
        );
    end

    dso_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .end_cyl   (end_cyl),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .in_pos    (s_tdata[dso_pkg::CYL_W-1:0]),
        .in_ready  (s_tready),
        .first_val (vals[0]),
        .cell_op   (cell_op),
        .count     (count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cyl   (out_cyl),
        .out_wrap  (m_tuser),
        .out_total (out_total),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(dso_pkg::OUT_DATA_W - dso_pkg::CYL_W - dso_pkg::SUM_W){1'b0}},
                      out_total, out_cyl};

endmodule

@@ hw/rtl/dso_chk.sv @@
// Port-level checker for the disk seek scheduler, bound to the top level.
// Depends on dso_pkg and on the top level's port names.
module dso_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dso_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    logic                      out_beat;
    logic [dso_pkg::SUM_W-1:0] total;
    logic                      open_reg;
    logic                      wrap_seen_reg;
    logic [dso_pkg::SUM_W-1:0] prev_total_reg;

    assign out_beat = m_tvalid && m_tready;
    assign total    = m_tdata[dso_pkg::CYL_W +: dso_pkg::SUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            wrap_seen_reg  <= 1'b0;
            prev_total_reg <= '0;
        end
        else if (out_beat)
        begin
            open_reg       <= !m_tlast;
            wrap_seen_reg  <= !m_tlast && (wrap_seen_reg || m_tuser);
            prev_total_reg <= total;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == dso_pkg::KIND_RUN |=> !s_tready)
        else $error("input taken right after a run beat");

    a_total_rises: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && open_reg |-> total >= prev_total_reg)
        else $error("total movement fell within a run");

    a_one_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && m_tuser |-> !wrap_seen_reg)
        else $error("second wrap beat in one run");

endmodule

bind disk_seek_order_cscan_clook dso_chk u_dso_chk (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the C-SCAN / C-LOOK disk seek scheduler.
// It predicts every visit beat with its own scheduler model and drives random traffic
// and stalls on both stream sides. Depends on dso_pkg and disk_seek_order_cscan_clook.
module tb_top;
    import dso_pkg::*;

    typedef struct {
        logic [CYL_W-1:0] cyl;
        logic             wrap;
        logic [SUM_W-1:0] total;
        logic             last;
    } visit_t;

    class seek_schedule_board;
        logic              mode;
        logic [NCYL_W-1:0] ncyl;
        logic [CYL_W-1:0]  requests[MAX_REQ];
        int                req_count;
        logic [CYL_W-1:0]  head;
        logic [SUM_W-1:0]  moved;
        visit_t            pending_visits[$];
        visit_t            run_visits[$];
        int                errors;
        int                runs;
        int                loads;
        int                dropped;
        int                visits_seen;

        function new();
            mode        = MODE_CSCAN;
            ncyl        = NCYL_RESET;
            req_count   = 0;
            head        = '0;
            moved       = '0;
            errors      = 0;
            runs        = 0;
            loads       = 0;
            dropped     = 0;
            visits_seen = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [NCYL_W-1:0] val);
            if (idx == REG_MODE)
                mode = val[0];
            else
                ncyl = val;
        endfunction

        function void move_to(logic [CYL_W-1:0] cyl, logic wrap);
            int     seek_len;
            int     acc;
            visit_t v;
            seek_len = (cyl >= head) ? int'(cyl) - int'(head) : int'(head) - int'(cyl);
            acc  = int'(moved) + seek_len;
            if (acc > int'(SUM_MAX))
                acc = int'(SUM_MAX);
            moved   = acc[SUM_W-1:0];
            head    = cyl;
            v.cyl   = cyl;
            v.wrap  = wrap;
            v.total = moved;
            v.last  = 1'b0;
            run_visits.push_back(v);
        endfunction

        function void note_beat(logic kind, logic [CYL_W-1:0] pos);
            logic [CYL_W-1:0] sorted[$];
            logic [CYL_W-1:0] t;
            logic [CYL_W-1:0] end_cyl;
            int               split;
            if (kind == KIND_LOAD)
            begin
                loads++;
                if (req_count < MAX_REQ)
                begin
                    requests[req_count] = pos;
                    req_count++;
                end
                else
                    dropped++;
                return;
            end
            runs++;
            run_visits.delete();
            for (int i = 0; i < req_count; i++)
                sorted.push_back(requests[i]);
            for (int i = 1; i < sorted.size(); i++)
                for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--)
                begin
                    t           = sorted[j];
                    sorted[j]   = sorted[j-1];
                    sorted[j-1] = t;
                end
            split = 0;
            while (split < sorted.size() && sorted[split] < pos)
                split++;
            head  = pos;
            moved = '0;
            if (mode == MODE_CLOOK && sorted.size() == 0)
                move_to(pos, 1'b0);
            else
            begin
                for (int i = split; i < sorted.size(); i++)
                    move_to(sorted[i], 1'b0);
                if (mode == MODE_CSCAN)
                begin
                    if (ncyl == 0)
                        end_cyl = '0;
                    else if (ncyl > 65536)
                        end_cyl = '1;
                    else
                        end_cyl = CYL_W'(ncyl - 1'b1);
                    move_to(end_cyl, 1'b0);
                    move_to('0, 1'b1);
                end
                else
                    move_to(sorted[0], 1'b1);
                for (int i = 0; i < split; i++)
                    move_to(sorted[i], 1'b0);
            end
            run_visits[run_visits.size()-1].last = 1'b1;
            foreach (run_visits[i])
                pending_visits.push_back(run_visits[i]);
            req_count = 0;
        endfunction

        function void flag(string what, int want, int got);
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_visit(logic [CYL_W-1:0] cyl, logic [SUM_W-1:0] total,
                                  logic wrap, logic last);
            visit_t want;
            visits_seen++;
            if (pending_visits.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected beat, expected none, actual cyl=%0d total=%0d",
                             $time, cyl, total);
                return;
            end
            want = pending_visits.pop_front();
            if (cyl !== want.cyl)
                flag("visit_cylinder", want.cyl, cyl);
            if (total !== want.total)
                flag("total_movement", want.total, total);
            if (wrap !== want.wrap)
                flag("is_wrap", want.wrap, wrap);
            if (last !== want.last)
                flag("last", want.last, last);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_addr  = '0;
    logic [NCYL_W-1:0]     cfg_wdata = '0;

    seek_schedule_board board;
    bit                 idle_on = 1'b1;
    int                 stall_left = 0;
    int                 settings_used = 0;
    int                 random_items = 0;
    int                 phase;

    disk_seek_order_cscan_clook dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && rst_n && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_visit(m_tdata[CYL_W-1:0], m_tdata[CYL_W +: SUM_W], m_tuser, m_tlast);

    task automatic send_beat(input logic kind, input logic [CYL_W-1:0] pos);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_beat(kind, pos);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending_visits.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic program_regs(input logic mode_val, input logic [NCYL_W-1:0] ncyl_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MODE;
        cfg_wdata <= NCYL_W'(mode_val);
        @(posedge clk);
        cfg_addr  <= REG_NCYL;
        cfg_wdata <= ncyl_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        board.set_reg(REG_MODE, NCYL_W'(mode_val));
        board.set_reg(REG_NCYL, ncyl_val);
        settings_used++;
    endtask

    function automatic logic [CYL_W-1:0] pick_cyl();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return CYL_W'(board.ncyl - NCYL_W'($urandom_range(0, 2)));
            3:       return CYL_W'($urandom_range(0, 31));
            default: return CYL_W'($urandom);
        endcase
    endfunction

    task automatic random_run();
        int               n;
        int               sel;
        logic [CYL_W-1:0] req;
        logic [CYL_W-1:0] hd;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            n = 0;
        else if (sel == 1)
            n = $urandom_range(MAX_REQ, MAX_REQ + 3);
        else
            n = $urandom_range(1, 8);
        req = pick_cyl();
        for (int i = 0; i < n; i++)
        begin
            req = pick_cyl();
            send_beat(KIND_LOAD, req);
            random_items++;
        end
        hd = ($urandom_range(0, 3) == 0) ? req : pick_cyl();
        send_beat(KIND_RUN, hd);
        random_items++;
    endtask

    initial
    begin
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(KIND_LOAD, 16'd0);
        send_beat(KIND_LOAD, 16'hFFFF);
        send_beat(KIND_LOAD, 16'd100);
        send_beat(KIND_LOAD, 16'd40000);
        send_beat(KIND_RUN, 16'd30000);
        send_beat(KIND_RUN, 16'hFFFF);
        settle();

        program_regs(MODE_CLOOK, NCYL_RESET);
        send_beat(KIND_RUN, 16'd1234);
        for (int i = 0; i <= MAX_REQ; i++)
            send_beat(KIND_LOAD, CYL_W'($urandom));
        send_beat(KIND_RUN, CYL_W'($urandom));
        settle();

        phase = 0;
        while (random_items < 85)
        begin
            if (random_items >= 65)
                idle_on = 1'b0;
            case (phase)
                0:       program_regs(MODE_CSCAN, 17'd1);
                1:       program_regs(MODE_CLOOK, 17'd65536);
                2:       program_regs(MODE_CSCAN, 17'd0);
                3:       program_regs(MODE_CLOOK, 17'h1FFFF);
                4:       program_regs(MODE_CSCAN, 17'd65537);
                5:       program_regs(MODE_CLOOK, 17'd1);
                6:       program_regs(MODE_CSCAN, 17'd65536);
                default: program_regs(1'($urandom_range(0, 1)),
                                      ($urandom_range(0, 1) == 1) ?
                                      NCYL_W'($urandom_range(1, 65536)) :
                                      NCYL_W'($urandom_range(0, 131071)));
            endcase
            for (int r = 0; r < 2 && random_items < 85; r++)
                random_run();
            settle();
            phase++;
        end

        $display("Covered %0d schedule runs from %0d request loads (%0d dropped on a full store),",
                 board.runs, board.loads, board.dropped);
        $display("with %0d visit beats checked across %0d register settings.",
                 board.visits_seen, settings_used);
        if (board.errors == 0 && board.pending_visits.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d visit beats still outstanding.", board.pending_visits.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
